@@ sv/assert_macros.svh @@
// Assertion macros used by the decoder top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ sv/sirc_pkg.sv @@
// Package: widths, register indexes, reset values and types of the SIRC decoder.
`timescale 1ns / 1ps

package sirc_pkg;

   localparam int BITS_PER_FRAME = 12;
   localparam int CODE_W         = 12;
   localparam int TIME_W         = 32;
   localparam int REG_W          = 16;
   localparam int CSR_IDX_W      = 2;

   // accumulator holds at least the reported code width
   localparam int ACC_W   = (BITS_PER_FRAME > CODE_W) ? BITS_PER_FRAME : CODE_W;
   localparam int ACC_IW  = (ACC_W > 1) ? $clog2(ACC_W) : 1;
   localparam int POS_W   = $clog2(BITS_PER_FRAME + 1);
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(BITS_PER_FRAME);

   localparam logic [CSR_IDX_W-1:0] REG_GAP_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ZERO_LOW      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BIT_SPLIT     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ONE_HIGH      = 2'd3;

   localparam logic [REG_W-1:0] GAP_THRESHOLD_RST = 16'd10000;
   localparam logic [REG_W-1:0] ZERO_LOW_RST      = 16'd600;
   localparam logic [REG_W-1:0] BIT_SPLIT_RST     = 16'd1500;
   localparam logic [REG_W-1:0] ONE_HIGH_RST      = 16'd3200;

   typedef struct packed {
      logic [REG_W-1:0] gap_threshold_us;
      logic [REG_W-1:0] zero_low_us;
      logic [REG_W-1:0] bit_split_us;
      logic [REG_W-1:0] one_high_us;
   } cfg_type;

   typedef struct packed {
      logic is_gap;
      logic is_zero;
      logic is_one;
   } class_type;

endpackage

@@ sv/sirc_classify.sv @@
// Interval classifier: sorts an edge-to-edge interval into gap, zero bit, one bit or none of them.
`timescale 1ns / 1ps

module sirc_classify (
   input  logic [sirc_pkg::TIME_W-1:0] delta,
   input  sirc_pkg::cfg_type           cfg,
   output sirc_pkg::class_type         cls
);

   logic [sirc_pkg::TIME_W-1:0] gap_ext;
   logic [sirc_pkg::TIME_W-1:0] zlo_ext;
   logic [sirc_pkg::TIME_W-1:0] split_ext;
   logic [sirc_pkg::TIME_W-1:0] ohi_ext;

   assign gap_ext   = sirc_pkg::TIME_W'(cfg.gap_threshold_us);
   assign zlo_ext   = sirc_pkg::TIME_W'(cfg.zero_low_us);
   assign split_ext = sirc_pkg::TIME_W'(cfg.bit_split_us);
   assign ohi_ext   = sirc_pkg::TIME_W'(cfg.one_high_us);

   // all bounds exclusive
   assign cls.is_gap  = delta > gap_ext;
   assign cls.is_zero = (delta > zlo_ext) && (delta < split_ext);
   assign cls.is_one  = (delta > split_ext) && (delta < ohi_ext);

endmodule

@@ sv/sirc_ir_decoder_learn_match.sv @@
// Top level: SIRC 12-bit IR frame decoder with learn-and-match of the first code.
// The edge beat is registered in the input register, then decoded into the result register,
//    which drives rsp_valid.
// Throughput: one edge beat per cycle while results are taken; a waiting result holds the
//    decode, and one further edge beat can then wait in the input register.
// Reset (synchronous): idle, learning mode, timestamp zero, registers at defaults.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sirc_ir_decoder_learn_match (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [sirc_pkg::TIME_W-1:0]   req_edge_time_us,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [sirc_pkg::CODE_W-1:0]   rsp_frame_code,
   output logic                          rsp_frame_error,
   output logic                          rsp_code_stored,
   output logic                          rsp_matched,
   input  logic                          csr_write_enable,
   input  logic [sirc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [sirc_pkg::REG_W-1:0]    csr_write_data
);

   sirc_pkg::cfg_type cfg_ff;

   logic                          s1_valid_ff;
   logic [sirc_pkg::TIME_W-1:0]   s1_time_ff;
   logic                          s1_advance;

   logic [sirc_pkg::TIME_W-1:0]   last_ff, last_in;
   logic [sirc_pkg::POS_W-1:0]    pos_ff, pos_in, pos_inc;
   logic                          in_frame_ff, in_frame_in;
   logic [sirc_pkg::ACC_W-1:0]    acc_ff, acc_in, acc_set;
   logic                          learned_valid_ff, learned_valid_in;
   logic [sirc_pkg::CODE_W-1:0]   learned_code_ff, learned_code_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [sirc_pkg::CODE_W-1:0]   code_ff, code_in;
   logic                          error_ff, error_in;
   logic                          code_stored_ff, code_stored_in;
   logic                          matched_ff, matched_in;
   logic                          produce;

   logic [sirc_pkg::TIME_W-1:0]   delta;
   sirc_pkg::class_type           cls;
   logic [sirc_pkg::CODE_W-1:0]   new_code;

   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gap_threshold_us <= sirc_pkg::GAP_THRESHOLD_RST;
         cfg_ff.zero_low_us      <= sirc_pkg::ZERO_LOW_RST;
         cfg_ff.bit_split_us     <= sirc_pkg::BIT_SPLIT_RST;
         cfg_ff.one_high_us      <= sirc_pkg::ONE_HIGH_RST;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            sirc_pkg::REG_GAP_THRESHOLD: cfg_ff.gap_threshold_us <= csr_write_data;
            sirc_pkg::REG_ZERO_LOW:      cfg_ff.zero_low_us      <= csr_write_data;
            sirc_pkg::REG_BIT_SPLIT:     cfg_ff.bit_split_us     <= csr_write_data;
            sirc_pkg::REG_ONE_HIGH:      cfg_ff.one_high_us      <= csr_write_data;
            default: ;
         endcase
      end
   end

   // input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_time_ff <= req_edge_time_us;
      end
   end

   assign delta = s1_time_ff - last_ff;

   sirc_classify u_classify (
      .delta (delta),
      .cfg   (cfg_ff),
      .cls   (cls)
   );

   assign pos_inc  = pos_ff + sirc_pkg::POS_W'(1);
   assign acc_set  = cls.is_one
                   ? (acc_ff | (sirc_pkg::ACC_W'(1) << pos_ff[sirc_pkg::ACC_IW-1:0]))
                   : acc_ff;
   assign new_code = acc_set[sirc_pkg::CODE_W-1:0];

   always_comb begin
      last_in          = last_ff;
      pos_in           = pos_ff;
      in_frame_in      = in_frame_ff;
      acc_in           = acc_ff;
      learned_valid_in = learned_valid_ff;
      learned_code_in  = learned_code_ff;
      produce          = 1'b0;
      code_in          = code_ff;
      error_in         = error_ff;
      code_stored_in   = code_stored_ff;
      matched_in       = matched_ff;
      if (s1_advance) begin
         last_in = s1_time_ff;
         if (cls.is_gap) begin
            // a gap restarts the frame, dropping any partial one
            in_frame_in = 1'b1;
            pos_in      = '0;
            acc_in      = '0;
         end else if (in_frame_ff) begin
            if (cls.is_zero || cls.is_one) begin
               acc_in = acc_set;
               if (pos_inc == sirc_pkg::POS_LAST) begin
                  in_frame_in = 1'b0;
                  pos_in      = '0;
                  produce     = 1'b1;
                  code_in     = new_code;
                  error_in    = 1'b0;
                  if (!learned_valid_ff) begin
                     learned_valid_in = 1'b1;
                     learned_code_in  = new_code;
                     code_stored_in   = 1'b1;
                     matched_in       = 1'b0;
                  end else begin
                     code_stored_in = 1'b0;
                     matched_in     = (new_code == learned_code_ff);
                  end
               end else begin
                  pos_in = pos_inc;
               end
            end else begin
               // bad interval aborts the frame
               in_frame_in    = 1'b0;
               pos_in         = '0;
               produce        = 1'b1;
               code_in        = '0;
               error_in       = 1'b1;
               code_stored_in = 1'b0;
               matched_in     = 1'b0;
            end
         end
      end
   end

   assign rsp_valid_in = (s1_advance && produce) || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff          <= '0;
         pos_ff           <= '0;
         in_frame_ff      <= 1'b0;
         acc_ff           <= '0;
         learned_valid_ff <= 1'b0;
         learned_code_ff  <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         last_ff          <= last_in;
         pos_ff           <= pos_in;
         in_frame_ff      <= in_frame_in;
         acc_ff           <= acc_in;
         learned_valid_ff <= learned_valid_in;
         learned_code_ff  <= learned_code_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff        <= code_in;
      error_ff       <= error_in;
      code_stored_ff <= code_stored_in;
      matched_ff     <= matched_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_frame_code  = code_ff;
   assign rsp_frame_error = error_ff;
   assign rsp_code_stored = code_stored_ff;
   assign rsp_matched     = matched_ff;

   `ASSERT_IMPLY(a_err_clean, clock, reset, rsp_valid_ff && error_ff,
      code_ff == '0 && !code_stored_ff && !matched_ff)
   `ASSERT_IMPLY(a_learn_xor_match, clock, reset, rsp_valid_ff, !(code_stored_ff && matched_ff))
   `ASSERT_IMPLY(a_learn_sets_valid, clock, reset, rsp_valid_ff && code_stored_ff,
      learned_valid_ff && learned_code_ff == code_ff)
   `ASSERT_IMPLY(a_idle_pos_zero, clock, reset, !in_frame_ff, pos_ff == '0)
   `ASSERT_IMPLY(a_pos_range, clock, reset, 1'b1, pos_ff < sirc_pkg::POS_LAST)
   `ASSERT_NEXT(a_learn_sticky, clock, reset, learned_valid_ff,
      learned_valid_ff && $stable(learned_code_ff))

endmodule

@@ dv/sirc_ir_decoder_learn_match_test.sv @@
// Testbench: SIRC IR decoder driven with edge timestamps and checked against a local decoder.
`timescale 1ns / 1ps

module sirc_ir_decoder_learn_match_test;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 8;

   typedef struct packed {
      logic [sirc_pkg::CODE_W-1:0] code;
      logic                        error;
      logic                        learned;
      logic                        matched;
   } frame_result_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic [sirc_pkg::TIME_W-1:0]    req_edge_time_us = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic [sirc_pkg::CODE_W-1:0]    rsp_frame_code;
   logic                           rsp_frame_error;
   logic                           rsp_code_stored;
   logic                           rsp_matched;
   logic                           csr_write_enable = 1'b0;
   logic [sirc_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [sirc_pkg::REG_W-1:0]     csr_write_data = '0;

   // decoder state as the block should hold it
   sirc_pkg::cfg_type           active_cfg = '{sirc_pkg::GAP_THRESHOLD_RST,
                                               sirc_pkg::ZERO_LOW_RST,
                                               sirc_pkg::BIT_SPLIT_RST,
                                               sirc_pkg::ONE_HIGH_RST};
   logic [sirc_pkg::TIME_W-1:0] prev_edge = '0;
   logic                        frame_open = 1'b0;
   logic [sirc_pkg::POS_W-1:0]  bit_count = '0;
   logic [sirc_pkg::ACC_W-1:0]  shift_code = '0;
   logic                        have_learned = 1'b0;
   logic [sirc_pkg::CODE_W-1:0] learned_code = '0;

   frame_result_type            expected_frames[$];
   frame_result_type            head_frame;
   logic [sirc_pkg::TIME_W-1:0] edge_clock = '0;
   int                          edges_sent = 0;
   int                          failures = 0;
   int                          cycle_count = 0;
   int                          send_idle_pct = 0;
   int                          recv_idle_pct = 0;

   sirc_ir_decoder_learn_match dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_edge_time_us (req_edge_time_us),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_frame_code   (rsp_frame_code),
      .rsp_frame_error  (rsp_frame_error),
      .rsp_code_stored  (rsp_code_stored),
      .rsp_matched      (rsp_matched),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("sirc_ir_decoder_learn_match: mismatch");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_frames.size() == 0) begin
            $error("result beat with no frame expected");
            failures++;
         end else begin
            head_frame = expected_frames.pop_front();
            if (rsp_frame_code !== head_frame.code) begin
               $error("frame_code: expected %h, actual %h", head_frame.code, rsp_frame_code);
               failures++;
            end
            if (rsp_frame_error !== head_frame.error) begin
               $error("frame_error: expected %b, actual %b", head_frame.error, rsp_frame_error);
               failures++;
            end
            if (rsp_code_stored !== head_frame.learned) begin
               $error("code_stored: expected %b, actual %b", head_frame.learned, rsp_code_stored);
               failures++;
            end
            if (rsp_matched !== head_frame.matched) begin
               $error("matched: expected %b, actual %b", head_frame.matched, rsp_matched);
               failures++;
            end
         end
      end
   end

   // Advances the decoder by one edge; returns 1 when a frame result is due.
   function automatic bit decode_edge(input logic [sirc_pkg::TIME_W-1:0] now,
                                      output frame_result_type res);
      logic [sirc_pkg::TIME_W-1:0] delta;
      delta = now - prev_edge;
      prev_edge = now;
      res = '0;
      if (delta > sirc_pkg::TIME_W'(active_cfg.gap_threshold_us)) begin
         frame_open = 1'b1;
         bit_count = '0;
         shift_code = '0;
         return 1'b0;
      end
      if (!frame_open) return 1'b0;
      if (delta > sirc_pkg::TIME_W'(active_cfg.zero_low_us) &&
          delta < sirc_pkg::TIME_W'(active_cfg.bit_split_us)) begin
         bit_count++;
      end else if (delta > sirc_pkg::TIME_W'(active_cfg.bit_split_us) &&
                   delta < sirc_pkg::TIME_W'(active_cfg.one_high_us)) begin
         shift_code[bit_count] = 1'b1;
         bit_count++;
      end else begin
         frame_open = 1'b0;
         bit_count = '0;
         res.error = 1'b1;
         return 1'b1;
      end
      if (bit_count < sirc_pkg::POS_LAST) return 1'b0;
      frame_open = 1'b0;
      bit_count = '0;
      res.code = shift_code[sirc_pkg::CODE_W-1:0];
      if (!have_learned) begin
         have_learned = 1'b1;
         learned_code = res.code;
         res.learned = 1'b1;
      end else begin
         res.matched = (res.code == learned_code);
      end
      return 1'b1;
   endfunction

   task automatic send_edge(input logic [sirc_pkg::TIME_W-1:0] t);
      frame_result_type res;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_edge_time_us <= t;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (decode_edge(t, res)) expected_frames.push_back(res);
      edge_clock = t;
      edges_sent++;
   endtask

   task automatic send_after(input logic [sirc_pkg::TIME_W-1:0] interval);
      send_edge(edge_clock + interval);
   endtask

   // Waits out every pending frame plus the pipeline, with valid low.
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_frames.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic program_registers(input sirc_pkg::cfg_type c);
      csr_write_enable <= 1'b1;
      csr_index <= sirc_pkg::REG_GAP_THRESHOLD;
      csr_write_data <= c.gap_threshold_us;
      @(posedge clock);
      csr_index <= sirc_pkg::REG_ZERO_LOW;
      csr_write_data <= c.zero_low_us;
      @(posedge clock);
      csr_index <= sirc_pkg::REG_BIT_SPLIT;
      csr_write_data <= c.bit_split_us;
      @(posedge clock);
      csr_index <= sirc_pkg::REG_ONE_HIGH;
      csr_write_data <= c.one_high_us;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      active_cfg = c;
   endtask

   // Interval inside an open window, leaning on its edges; any value up to 65535 when the window is empty.
   function automatic logic [sirc_pkg::TIME_W-1:0] window_interval(
         input logic [sirc_pkg::TIME_W-1:0] lo,
         input logic [sirc_pkg::TIME_W-1:0] hi);
      if (hi <= lo + 1) return $urandom_range(65535);
      case ($urandom_range(3))
         0:       return lo + 1;
         1:       return hi - 1;
         default: return $urandom_range(hi - 1, lo + 1);
      endcase
   endfunction

   function automatic logic [sirc_pkg::TIME_W-1:0] gap_interval();
      logic [sirc_pkg::TIME_W-1:0] base;
      base = sirc_pkg::TIME_W'(active_cfg.gap_threshold_us) + 1;
      case ($urandom_range(19))
         0, 1:    return base;
         2:       return $urandom_range(32'hFFFF_FFFF, base);
         default: return base + $urandom_range(40000);
      endcase
   endfunction

   function automatic logic [sirc_pkg::TIME_W-1:0] bad_interval();
      case ($urandom_range(6))
         0:       return sirc_pkg::TIME_W'(active_cfg.zero_low_us);
         1:       return sirc_pkg::TIME_W'(active_cfg.bit_split_us);
         2:       return sirc_pkg::TIME_W'(active_cfg.one_high_us);
         3:       return '0;
         4:       return sirc_pkg::TIME_W'(active_cfg.one_high_us) + 1 + $urandom_range(2000);
         5:       return sirc_pkg::TIME_W'(active_cfg.gap_threshold_us);
         default: return $urandom_range(active_cfg.zero_low_us);
      endcase
   endfunction

   // Gap, then one interval per bit; a corrupted frame ends at its bad interval.
   task automatic send_frame(input logic [sirc_pkg::CODE_W-1:0] code, input bit corrupt);
      int bad_at;
      logic [sirc_pkg::TIME_W-1:0] lo;
      logic [sirc_pkg::TIME_W-1:0] hi;
      bad_at = corrupt ? $urandom_range(sirc_pkg::BITS_PER_FRAME - 1) : -1;
      send_after(gap_interval());
      for (int i = 0; i < sirc_pkg::BITS_PER_FRAME; i++) begin
         if (i == bad_at) begin
            // sometimes a fresh gap in mid-frame instead of a bad interval
            send_after($urandom_range(3) == 0 ? gap_interval() : bad_interval());
            break;
         end
         if (code[i % sirc_pkg::CODE_W]) begin
            lo = sirc_pkg::TIME_W'(active_cfg.bit_split_us);
            hi = sirc_pkg::TIME_W'(active_cfg.one_high_us);
         end else begin
            lo = sirc_pkg::TIME_W'(active_cfg.zero_low_us);
            hi = sirc_pkg::TIME_W'(active_cfg.bit_split_us);
         end
         send_after(window_interval(lo, hi));
      end
   endtask

   task automatic run_traffic(input int n_items);
      int start;
      int pick;
      logic [sirc_pkg::CODE_W-1:0] code;
      start = edges_sent;
      while (edges_sent - start < n_items) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            case ($urandom_range(9))
               0, 1, 2, 3: code = have_learned ? learned_code : sirc_pkg::CODE_W'($urandom);
               4:          code = '0;
               5:          code = '1;
               default:    code = sirc_pkg::CODE_W'($urandom);
            endcase
            send_frame(code, $urandom_range(99) < 15);
         end else if (pick < 92) begin
            send_after($urandom_range(sirc_pkg::TIME_W'(active_cfg.gap_threshold_us) + 200));
         end else begin
            send_after($urandom);
         end
      end
   endtask

   task automatic run_setting(input sirc_pkg::cfg_type c, input int n_items);
      drain();
      program_registers(c);
      run_traffic(n_items);
   endtask

   // Reset defaults: idle edge, learned frame, exact bounds, mid-frame gap, timestamp wrap.
   task automatic test_directed_frames();
      logic [sirc_pkg::CODE_W-1:0] code;
      code = 12'hA5C;
      send_edge(32'd0);
      send_edge(32'd20000);
      for (int i = 0; i < sirc_pkg::BITS_PER_FRAME; i++) begin
         send_after(code[i] ? 32'd2000 : 32'd1000);
      end
      send_after(32'd10001);
      send_after(sirc_pkg::TIME_W'(sirc_pkg::BIT_SPLIT_RST));
      send_after(32'd10001);
      send_after(32'd601);
      send_after(32'd1501);
      send_after(sirc_pkg::TIME_W'(sirc_pkg::ZERO_LOW_RST));
      send_after(32'd30000);
      send_after(32'd3199);
      send_after(32'd50000);
      send_after(sirc_pkg::TIME_W'(sirc_pkg::ONE_HIGH_RST));
      send_edge(32'hFFFF_FFFF);
      send_edge(32'd1024);
      send_after(32'd0);
   endtask

   task automatic test_default_timing();
      run_setting('{sirc_pkg::GAP_THRESHOLD_RST, sirc_pkg::ZERO_LOW_RST,
                    sirc_pkg::BIT_SPLIT_RST, sirc_pkg::ONE_HIGH_RST}, 250);
   endtask

   task automatic test_zero_registers();
      run_setting('{16'd0, 16'd0, 16'd0, 16'd0}, 150);
   endtask

   task automatic test_max_registers();
      run_setting('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 150);
   endtask

   task automatic test_narrow_windows();
      run_setting('{16'd200, 16'd100, 16'd102, 16'd104}, 250);
   endtask

   task automatic test_random_ordered_timing();
      sirc_pkg::cfg_type c;
      for (int n = 0; n < 5; n++) begin
         c.zero_low_us      = sirc_pkg::REG_W'($urandom_range(4000));
         c.bit_split_us     = c.zero_low_us + sirc_pkg::REG_W'($urandom_range(3000, 1));
         c.one_high_us      = c.bit_split_us + sirc_pkg::REG_W'($urandom_range(4000, 1));
         c.gap_threshold_us = c.one_high_us + sirc_pkg::REG_W'($urandom_range(40000));
         run_setting(c, 70);
      end
   endtask

   task automatic test_random_any_timing();
      for (int n = 0; n < 5; n++) begin
         run_setting(sirc_pkg::cfg_type'({$urandom, $urandom}), 70);
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 31;
      recv_idle_pct = 58;
      test_directed_frames();
      test_default_timing();
      test_zero_registers();
      send_idle_pct = 58;
      recv_idle_pct = 31;
      test_max_registers();
      test_narrow_windows();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_ordered_timing();
      test_random_any_timing();
      drain();
      if (failures == 0) begin
         $display("sirc_ir_decoder_learn_match: match");
      end else begin
         $display("sirc_ir_decoder_learn_match: mismatch");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+sv
sv/sirc_pkg.sv
sv/sirc_classify.sv
sv/sirc_ir_decoder_learn_match.sv
dv/sirc_ir_decoder_learn_match_test.sv
